// ----- hdl/lud_pkg.sv -----
// shared types, constants and saturating arithmetic for the lens undistortion
// source address core; used by every module of the block but the delay line
`default_nettype none

package lud_pkg;

  typedef logic signed [63:0] word_t;

  // configuration register indexes
  localparam logic [3:0] REG_K1 = 4'd0;
  localparam logic [3:0] REG_K2 = 4'd1;
  localparam logic [3:0] REG_P1 = 4'd2;
  localparam logic [3:0] REG_P2 = 4'd3;
  localparam logic [3:0] REG_FX = 4'd4;
  localparam logic [3:0] REG_FY = 4'd5;
  localparam logic [3:0] REG_CX = 4'd6;
  localparam logic [3:0] REG_CY = 4'd7;

  localparam logic signed [31:0] K1_RST = -32'sd304307141;
  localparam logic signed [31:0] K2_RST = 32'sd79412947;
  localparam logic signed [31:0] P1_RST = 32'sd207866;
  localparam logic signed [31:0] P2_RST = 32'sd18918;
  localparam logic [27:0] FX_RST = 28'd30058349;
  localparam logic [27:0] FY_RST = 28'd29969351;
  localparam logic [27:0] CX_RST = 28'd24065802;
  localparam logic [27:0] CY_RST = 28'd16277504;

  localparam int DEF_FRAME_WIDTH  = 752;
  localparam int DEF_FRAME_HEIGHT = 480;

  localparam word_t SAT_POS = 64'sh4000_0000_0000_0000;
  localparam word_t SAT_NEG = -64'sh4000_0000_0000_0000;
  localparam word_t Q30_ONE = 64'sh0000_0000_4000_0000;

  // divider: 28 bit magnitude shifted up by 30 fraction bits
  localparam int MAG_W      = 28;
  localparam int FRAC_W     = 30;
  localparam int DIV_NBITS  = MAG_W + FRAC_W;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (DIV_NBITS + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_LAT    = DIV_STAGES + 2;

  localparam int MUL_LAT = 4;
  // input register, divider, five multiplier levels, eight add/compare stages
  localparam int TOT_LAT = 1 + DIV_LAT + 5 * MUL_LAT + 8;

  function automatic word_t sadd(input word_t a, input word_t b);
    word_t s;
    s = a + b;
    if (s > SAT_POS) return SAT_POS;
    if (s < SAT_NEG) return SAT_NEG;
    return s;
  endfunction

  typedef struct packed {
    word_t s1;
    word_t tp1;
    word_t tp2;
    word_t p2ax;
    word_t p1ay;
  } e_t;

  typedef struct packed {
    word_t tp1;
    word_t tp2;
    word_t p2ax;
    word_t p1ay;
  } g_t;

endpackage

`default_nettype wire

// ----- hdl/lud_dly.sv -----
// fixed-length register delay line for payload alignment
// depends on nothing
`default_nettype none

module lud_dly #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

`default_nettype wire

// ----- hdl/lud_div.sv -----
// pipelined restoring divider: (pix*2^16 - center) * 2^30 / focal, signed Q.30
// depends on lud_pkg
`default_nettype none

module lud_div
  import lud_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [9:0]  pix_i,
  input  wire logic [MAG_W-1:0] center_i,
  input  wire logic [MAG_W-1:0] focal_i,
  output word_t            quo_o
);

  logic signed [MAG_W:0] diff;
  logic [MAG_W-1:0]      mag;
  logic [MAG_W-1:0]      rem_q [DIV_STAGES+1];
  logic [DIV_NBITS-1:0]  num_q [DIV_STAGES+1];
  logic                  neg_q [DIV_STAGES+1];
  word_t                 quo_q;
  word_t                 qext;

  assign diff = $signed({3'b000, pix_i, 16'h0000}) - $signed({1'b0, center_i});
  assign mag  = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    num_q[0] <= {mag, {FRAC_W{1'b0}}};
    neg_q[0] <= diff[MAG_W];
  end

  // dividend bits shift out at the top, quotient bits shift in at the bottom
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    logic [MAG_W-1:0]     rem_c;
    logic [DIV_NBITS-1:0] num_c;
    logic [MAG_W:0]       trial;

    always_comb begin
      rem_c = rem_q[k-1];
      num_c = num_q[k-1];
      trial = '0;
      for (int s = 0; s < DIV_STEP; s++) begin
        trial = {rem_c, num_c[DIV_NBITS-1]};
        num_c = {num_c[DIV_NBITS-2:0], 1'b0};
        if (trial >= {1'b0, focal_i}) begin
          rem_c    = MAG_W'(trial - {1'b0, focal_i});
          num_c[0] = 1'b1;
        end else begin
          rem_c = trial[MAG_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_c;
      num_q[k] <= num_c;
      neg_q[k] <= neg_q[k-1];
    end
  end

  assign qext = word_t'({{(64-DIV_NBITS){1'b0}}, num_q[DIV_STAGES]});

  always_ff @(posedge clk_i) begin
    quo_q <= neg_q[DIV_STAGES] ? -qext : qext;
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ----- hdl/lud_mul.sv -----
// four-stage Q.30 multiplier: exact product of magnitudes from 32 bit
// partial products, shifted by 30, saturated to +-2^62; depends on lud_pkg
`default_nettype none

module lud_mul
  import lud_pkg::*;
(
  input  wire logic  clk_i,
  input  wire word_t a_i,
  input  wire word_t b_i,
  output word_t      p_o
);

  logic         neg1_q, neg2_q, neg3_q;
  logic [62:0]  ma_q, mb_q;
  logic [63:0]  p00_q;
  logic [62:0]  p01_q, p10_q;
  logic [61:0]  p11_q;
  logic [125:0] prod_q;
  logic [95:0]  shf;
  logic [62:0]  mag;
  word_t        res_q;

  always_ff @(posedge clk_i) begin
    neg1_q <= a_i[63] ^ b_i[63];
    ma_q   <= a_i[63] ? 63'(-a_i) : a_i[62:0];
    mb_q   <= b_i[63] ? 63'(-b_i) : b_i[62:0];

    neg2_q <= neg1_q;
    p00_q  <= ma_q[31:0] * mb_q[31:0];
    p01_q  <= ma_q[31:0] * mb_q[62:32];
    p10_q  <= ma_q[62:32] * mb_q[31:0];
    p11_q  <= ma_q[62:32] * mb_q[62:32];

    neg3_q <= neg2_q;
    prod_q <= 126'(p00_q) + (126'(p01_q) << 32) + (126'(p10_q) << 32)
            + (126'(p11_q) << 64);

    res_q  <= neg3_q ? -word_t'({1'b0, mag}) : word_t'({1'b0, mag});
  end

  assign shf = prod_q[125:30];
  assign mag = (shf > 96'(SAT_POS)) ? SAT_POS[62:0] : shf[62:0];
  assign p_o = res_q;

endmodule

`default_nettype wire

// ----- hdl/lens_undistort_source_address_core.sv -----
// lens undistortion source address core: radial/tangential remap of one
// output pixel coordinate per clock cycle to its source pixel and address
// throughput: one transaction per cycle, busy is never raised; the divider
//   and multiplier units are fully pipelined and the receiver cannot stall
// reset: rst_ni clears the pipeline valid bits and loads the default camera
`default_nettype none

module lens_undistort_source_address_core
  import lud_pkg::*;
#(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [9:0]  out_col_i,
  input  wire logic [8:0]  out_row_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             done_o,
  output logic [9:0]       src_col_o,
  output logic [8:0]       src_row_o,
  output logic [18:0]      src_address_o,
  output logic             in_bounds_o
);

  localparam word_t LIM_U = 64'(FRAME_WIDTH) << 16;
  localparam word_t LIM_V = 64'(FRAME_HEIGHT) << 16;

  logic signed [31:0] k1_q, k2_q, p1_q, p2_q;
  logic [27:0]        fx_q, fy_q, cx_q, cy_q;
  logic [TOT_LAT-1:0] vld_q;
  logic               accept;

  logic [9:0] col_q;
  logic [8:0] row_q;

  word_t x, y, xx, yy, xy;
  word_t r2_q, xx2_q, yy2_q, xyc_q;
  word_t ax_q, ay_q, r2d_q, xyd_q;
  word_t r4, k1r2, p1xy, p2xy, p2ax, p1ay, k2r4;
  e_t    e_q, e_al;
  word_t rad_q;
  g_t    f_q, g_al;
  word_t x_al, y_al, xrad, yrad;
  word_t xd1_q, yd1_q, p2axh_q, tp2h_q;
  word_t xd_q, yd_q, mx, my, su_q, sv_q;
  logic        ok_q;
  logic [11:0] colf_q, rowf_q;
  logic        inb;
  logic [24:0] addr;

  logic [9:0]  src_col_q;
  logic [8:0]  src_row_q;
  logic [18:0] src_addr_q;
  logic        inb_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q <= K1_RST;
      k2_q <= K2_RST;
      p1_q <= P1_RST;
      p2_q <= P2_RST;
      fx_q <= FX_RST;
      fy_q <= FY_RST;
      cx_q <= CX_RST;
      cy_q <= CY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_K1:  k1_q <= cfg_data_i;
        REG_K2:  k2_q <= cfg_data_i;
        REG_P1:  p1_q <= cfg_data_i;
        REG_P2:  p2_q <= cfg_data_i;
        REG_FX:  fx_q <= cfg_data_i[27:0];
        REG_FY:  fy_q <= cfg_data_i[27:0];
        REG_CX:  cx_q <= cfg_data_i[27:0];
        REG_CY:  cy_q <= cfg_data_i[27:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TOT_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= out_col_i;
    row_q <= out_row_i;
  end

  // normalise
  lud_div u_div_x (.clk_i, .pix_i(col_q), .center_i(cx_q), .focal_i(fx_q), .quo_o(x));
  lud_div u_div_y (.clk_i, .pix_i({1'b0, row_q}), .center_i(cy_q), .focal_i(fy_q), .quo_o(y));

  lud_mul u_mul_xx (.clk_i, .a_i(x), .b_i(x), .p_o(xx));
  lud_mul u_mul_yy (.clk_i, .a_i(y), .b_i(y), .p_o(yy));
  lud_mul u_mul_xy (.clk_i, .a_i(x), .b_i(y), .p_o(xy));

  always_ff @(posedge clk_i) begin
    r2_q  <= sadd(xx, yy);
    xx2_q <= sadd(xx, xx);
    yy2_q <= sadd(yy, yy);
    xyc_q <= xy;
    ax_q  <= sadd(r2_q, xx2_q);
    ay_q  <= sadd(r2_q, yy2_q);
    r2d_q <= r2_q;
    xyd_q <= xyc_q;
  end

  lud_mul u_mul_r4   (.clk_i, .a_i(r2d_q), .b_i(r2d_q), .p_o(r4));
  lud_mul u_mul_k1r2 (.clk_i, .a_i(word_t'(k1_q)), .b_i(r2d_q), .p_o(k1r2));
  lud_mul u_mul_p1xy (.clk_i, .a_i(word_t'(p1_q)), .b_i(xyd_q), .p_o(p1xy));
  lud_mul u_mul_p2xy (.clk_i, .a_i(word_t'(p2_q)), .b_i(xyd_q), .p_o(p2xy));
  lud_mul u_mul_p2ax (.clk_i, .a_i(word_t'(p2_q)), .b_i(ax_q), .p_o(p2ax));
  lud_mul u_mul_p1ay (.clk_i, .a_i(word_t'(p1_q)), .b_i(ay_q), .p_o(p1ay));
  lud_mul u_mul_k2r4 (.clk_i, .a_i(word_t'(k2_q)), .b_i(r4), .p_o(k2r4));

  always_ff @(posedge clk_i) begin
    e_q.s1   <= sadd(Q30_ONE, k1r2);
    e_q.tp1  <= sadd(p1xy, p1xy);
    e_q.tp2  <= sadd(p2xy, p2xy);
    e_q.p2ax <= p2ax;
    e_q.p1ay <= p1ay;
  end

  // line up the first radial sum and the tangential terms with the k2 product
  lud_dly #(.WIDTH($bits(e_t)), .DEPTH(MUL_LAT - 1)) u_dly_e (
    .clk_i, .d_i(e_q), .q_o(e_al)
  );

  always_ff @(posedge clk_i) begin
    rad_q      <= sadd(e_al.s1, k2r4);
    f_q.tp1    <= e_al.tp1;
    f_q.tp2    <= e_al.tp2;
    f_q.p2ax   <= e_al.p2ax;
    f_q.p1ay   <= e_al.p1ay;
  end

  lud_dly #(.WIDTH(64), .DEPTH(3 * MUL_LAT + 3)) u_dly_x (.clk_i, .d_i(x), .q_o(x_al));
  lud_dly #(.WIDTH(64), .DEPTH(3 * MUL_LAT + 3)) u_dly_y (.clk_i, .d_i(y), .q_o(y_al));
  lud_dly #(.WIDTH($bits(g_t)), .DEPTH(MUL_LAT)) u_dly_g (.clk_i, .d_i(f_q), .q_o(g_al));

  lud_mul u_mul_xrad (.clk_i, .a_i(x_al), .b_i(rad_q), .p_o(xrad));
  lud_mul u_mul_yrad (.clk_i, .a_i(y_al), .b_i(rad_q), .p_o(yrad));

  // summation order matters under saturation
  always_ff @(posedge clk_i) begin
    xd1_q   <= sadd(xrad, g_al.tp1);
    yd1_q   <= sadd(yrad, g_al.p1ay);
    p2axh_q <= g_al.p2ax;
    tp2h_q  <= g_al.tp2;
    xd_q    <= sadd(xd1_q, p2axh_q);
    yd_q    <= sadd(yd1_q, tp2h_q);
  end

  lud_mul u_mul_fx (.clk_i, .a_i(word_t'({36'b0, fx_q})), .b_i(xd_q), .p_o(mx));
  lud_mul u_mul_fy (.clk_i, .a_i(word_t'({36'b0, fy_q})), .b_i(yd_q), .p_o(my));

  assign inb = !su_q[63] && !sv_q[63] && (su_q < LIM_U) && (sv_q < LIM_V)
            && (fx_q != '0) && (fy_q != '0);
  assign addr = 25'(rowf_q) * 25'(FRAME_WIDTH) + 25'(colf_q);

  always_ff @(posedge clk_i) begin
    su_q   <= sadd(mx, word_t'({36'b0, cx_q}));
    sv_q   <= sadd(my, word_t'({36'b0, cy_q}));
    ok_q   <= inb;
    colf_q <= inb ? su_q[27:16] : 12'd0;
    rowf_q <= inb ? sv_q[27:16] : 12'd0;
    src_col_q  <= colf_q[9:0];
    src_row_q  <= rowf_q[8:0];
    src_addr_q <= addr[18:0];
    inb_q      <= ok_q;
  end

  assign done_o        = vld_q[TOT_LAT-1];
  assign src_col_o     = src_col_q;
  assign src_row_o     = src_row_q;
  assign src_address_o = src_addr_q;
  assign in_bounds_o   = inb_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_inside_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && in_bounds_o |-> (32'(src_col_o) < FRAME_WIDTH)
                           && (32'(src_row_o) < FRAME_HEIGHT))
    else $error("in-bounds result lies outside the frame");

  a_outside_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !in_bounds_o |-> src_col_o == '0 && src_row_o == '0
                            && src_address_o == '0)
    else $error("out-of-bounds result carries a non-zero address");

endmodule

`default_nettype wire
